>>> design/dsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsp_pkg;

	localparam int NODE_COUNT  = 16;
	localparam int WEIGHT_BITS = 6;
	localparam int MAX_RESULTS = 16;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int CNT_W       = $clog2(NODE_COUNT + 1);
	localparam int K_W         = $clog2(MAX_RESULTS);
	localparam int ADDR_W      = 2 * NODE_W;

	localparam logic [WEIGHT_BITS-1:0] NO_EDGE     = {WEIGHT_BITS{1'b1}};
	localparam logic [CNT_W-1:0]       ACTIVE_RST  = CNT_W'(11);
	localparam logic [CNT_W-1:0]       NODE_MAX    = CNT_W'(NODE_COUNT);
	localparam logic [K_W-1:0]         K_LAST      = K_W'(MAX_RESULTS - 1);

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                   kind;
		logic [3:0]             row_node;
		logic [3:0]             col_node;
		logic [5:0]             edge_weight;
		logic [3:0]             source_node;
		logic [3:0]             dest_node;
	} in_item_t;

	typedef struct packed {
		logic [3:0]             path_node;
		logic [5:0]             total_distance;
		logic                   found;
		logic                   last_of_run;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic start;
		logic scan_init;
		logic scan;
		logic select;
		logic relax;
		logic check;
		logic emit;
		logic nopath;
	} dsp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic query_bad;
		logic scan_last;
		logic picked;
		logic relax_done;
		logic unreachable;
		logic slot_free;
		logic emit_last;
	} dsp_stat_t;

endpackage

`default_nettype wire

>>> design/dsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dsp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_kind,
	output logic                  in_stall,
	input  wire dsp_pkg::dsp_stat_t stat,
	output dsp_pkg::dsp_cmd_t     cmd
);
	import dsp_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_SEL    = 7'b0000100,
		S_RELAX  = 7'b0001000,
		S_CHECK  = 7'b0010000,
		S_EMIT   = 7'b0100000,
		S_NOPATH = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_kind == KIND_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = stat.query_bad ? S_NOPATH : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_d = S_SEL;
			end
			S_SEL: begin
				cmd.select = 1'b1;
				state_d    = stat.picked ? S_RELAX : S_CHECK;
			end
			S_RELAX: begin
				cmd.relax = 1'b1;
				if (stat.relax_done) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.unreachable ? S_NOPATH : S_EMIT;
			end
			S_EMIT: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) state_d = S_IDLE;
				end
			end
			S_NOPATH: begin
				if (stat.slot_free) begin
					cmd.nopath = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> design/dsp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dsp_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dsp_pkg::in_item_t in_data,
	input  wire logic              cfg_we,
	input  wire logic [4:0]        cfg_data,
	input  wire dsp_pkg::dsp_cmd_t cmd,
	output dsp_pkg::dsp_stat_t     stat,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dsp_pkg::out_item_t     out_data
);
	import dsp_pkg::*;

	logic [WEIGHT_BITS-1:0] wmem [NODE_COUNT*NODE_COUNT];
	logic [ADDR_W-1:0]      rd_addr;
	logic [WEIGHT_BITS-1:0] rd_data_s1;
	logic                   rd_valid_s1;
	logic [NODE_W-1:0]      rd_idx_s1;

	logic [CNT_W-1:0]       active_q;
	logic [CNT_W-1:0]       n_eff;
	logic [CNT_W-1:0]       n_q;
	logic [NODE_W-1:0]      src_q, dst_q;

	logic [WEIGHT_BITS-1:0] dist_q [NODE_COUNT];
	logic                   settled_q [NODE_COUNT];
	logic [NODE_W-1:0]      pred_q [NODE_COUNT];

	logic [CNT_W-1:0]       idx_q;
	logic [NODE_W-1:0]      pick_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic                   picked_q;

	logic [NODE_W-1:0]      node_q;
	logic [WEIGHT_BITS-1:0] total_q;
	logic [K_W-1:0]         k_q;

	logic                   out_valid_q;
	out_item_t              out_q;

	logic [NODE_W-1:0]      scan_i;
	logic                   scan_take;
	logic                   issue;
	logic [WEIGHT_BITS:0]   relax_sum;
	logic                   relax_hit;
	logic [WEIGHT_BITS-1:0] dist_src;
	logic                   emit_last;

	// clamp the active count into 1..NODE_COUNT
	always_comb begin
		if (active_q == '0)          n_eff = CNT_W'(1);
		else if (active_q > NODE_MAX) n_eff = NODE_MAX;
		else                          n_eff = active_q;
	end

	assign scan_i    = idx_q[NODE_W-1:0];
	assign scan_take = !settled_q[scan_i] && (dist_q[scan_i] < best_q);
	assign issue     = cmd.relax && (idx_q < n_q);
	assign rd_addr   = {pick_q, idx_q[NODE_W-1:0]};
	assign relax_sum = {1'b0, best_q} + {1'b0, rd_data_s1};
	assign relax_hit = rd_valid_s1 && !settled_q[rd_idx_s1] && (rd_data_s1 != NO_EDGE)
		&& (relax_sum < {1'b0, dist_q[rd_idx_s1]});
	assign dist_src  = dist_q[src_q];
	assign emit_last = (node_q == dst_q) || (k_q == K_LAST);

	always_comb begin
		stat             = '0;
		stat.query_bad   = ({1'b0, in_data.source_node} >= n_eff)
			|| ({1'b0, in_data.dest_node} >= n_eff);
		stat.scan_last   = (idx_q == n_q - CNT_W'(1));
		stat.picked      = picked_q;
		stat.relax_done  = !(idx_q < n_q) && !rd_valid_s1;
		stat.unreachable = (dist_src == NO_EDGE);
		stat.slot_free   = !out_valid_q || !out_stall;
		stat.emit_last   = emit_last;
	end

	// weight matrix, registered read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wmem[{in_data.row_node, in_data.col_node}] <= in_data.edge_weight;
		end
		rd_data_s1 <= wmem[rd_addr];
		rd_idx_s1  <= idx_q[NODE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				dist_q[i]    <= NO_EDGE;
				settled_q[i] <= 1'b0;
				pred_q[i]    <= '0;
			end
			rd_valid_s1 <= 1'b0;
			idx_q       <= '0;
			picked_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (cmd.start) begin
				for (int i = 0; i < NODE_COUNT; i++) begin
					dist_q[i]    <= (NODE_W'(i) == in_data.dest_node) ? '0 : NO_EDGE;
					settled_q[i] <= 1'b0;
				end
			end
			if (cmd.start || cmd.scan_init) begin
				idx_q    <= '0;
				picked_q <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + CNT_W'(1);
				if (scan_take) picked_q <= 1'b1;
			end
			if (cmd.select) begin
				idx_q <= '0;
				if (picked_q) settled_q[pick_q] <= 1'b1;
			end
			if (issue) idx_q <= idx_q + CNT_W'(1);
			if (relax_hit) begin
				dist_q[rd_idx_s1] <= relax_sum[WEIGHT_BITS-1:0];
				pred_q[rd_idx_s1] <= pick_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q   <= n_eff;
			src_q <= in_data.source_node;
			dst_q <= in_data.dest_node;
		end
		if (cmd.start || cmd.scan_init) begin
			best_q <= NO_EDGE;
		end
		if (cmd.scan && scan_take) begin
			best_q <= dist_q[scan_i];
			pick_q <= scan_i;
		end
		if (cmd.check) begin
			node_q  <= src_q;
			total_q <= dist_src;
			k_q     <= '0;
		end
		if (cmd.emit) begin
			node_q <= pred_q[node_q];
			k_q    <= k_q + K_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.nopath) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.path_node      <= node_q;
			out_q.total_distance <= total_q;
			out_q.found          <= 1'b1;
			out_q.last_of_run    <= emit_last;
		end else if (cmd.nopath) begin
			out_q.path_node      <= src_q;
			out_q.total_distance <= NO_EDGE;
			out_q.found          <= 1'b0;
			out_q.last_of_run    <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> design/dijkstra_shortest_path_core.sv
// Load item: writes the 6-bit weight into the 256-entry matrix RAM.
// Query item: up to n rounds of (serial minimum scan, select, row sweep through the
// registered RAM read port), a closing scan and select, a check, then one path node
// per cycle unless stalled; a bad or unreachable query gives one not-found item.
// One item in flight at a time; results leave through an output register.
// Reset clears control, distances, settled flags, predecessors; active count 11.
`timescale 1ns / 1ps
`default_nettype none

module dijkstra_shortest_path_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire dsp_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dsp_pkg::out_item_t     out_data,
	input  wire logic              cfg_we,
	input  wire logic [4:0]        cfg_data
);
	import dsp_pkg::*;

	dsp_cmd_t  cmd;
	dsp_stat_t stat;

	dsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
